>>> rtl/core/dfrc_pkg.sv
// ----------------------------------------------------------------------------
// dfrc_pkg: shared definitions for the detection filter and rescale block
// Widths, constants, register indexes and the word that travels through the
// divider cell chain.
// ----------------------------------------------------------------------------
package dfrc_pkg;

	localparam int NUM_CLASSES     = 80;
	localparam int MASK_W          = 80;
	localparam int DEFAULT_PROCESS = 224;
	localparam int NUM_LANES       = 4;

	localparam int SCORE_W  = 16;
	localparam int LABEL_W  = 9;
	localparam int COORD_W  = 16;
	localparam int IMG_W    = 13;
	localparam int PROC_W   = 12;
	localparam int PIX_W    = 13;
	localparam int CLASS_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MASK_LO_W  = 64;
	localparam int MASK_HI_W  = 16;

	// Magnitude of a coordinate times an image size stays below 2**28.
	localparam int MAG_W = COORD_W + IMG_W - 1;
	localparam int REM_W = PROC_W;
	localparam int SV_W  = MAG_W + 1;
	localparam int TR_W  = SV_W - 4;

	localparam int PIX_MAX = 4095;
	localparam int PIX_MIN = -4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SCORE       = 3'd0,
		REG_CLASS_MASK_LOW  = 3'd1,
		REG_CLASS_MASK_HIGH = 3'd2,
		REG_PROCESS_WIDTH   = 3'd3,
		REG_PROCESS_HEIGHT  = 3'd4,
		REG_IMAGE_WIDTH     = 3'd5,
		REG_IMAGE_HEIGHT    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [CLASS_W-1:0] class_id;
		logic [SCORE_W-1:0] confidence;
		logic               box_valid;
		logic               frame_end;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] dq;
		logic             neg;
	} lane_t;

	typedef struct packed {
		side_t                     side;
		lane_t [NUM_LANES-1:0]     lane;
	} div_word_t;

endpackage

>>> rtl/core/dfrc_div_cell.sv
// ----------------------------------------------------------------------------
// dfrc_div_cell: one restoring division step
// Produces one quotient bit for each of the four corner lanes and passes the
// item on to the next cell.
// ----------------------------------------------------------------------------
module dfrc_div_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vld_in,
	input  dfrc_pkg::div_word_t            word_in,
	input  logic [dfrc_pkg::PROC_W-1:0]    div_x,
	input  logic [dfrc_pkg::PROC_W-1:0]    div_y,
	output logic                           vld_out,
	output dfrc_pkg::div_word_t            word_out
);

	logic                vld_q;
	dfrc_pkg::div_word_t word_q;
	dfrc_pkg::div_word_t word_next;

	always_comb begin
		logic [dfrc_pkg::PROC_W-1:0] divisor;
		logic [dfrc_pkg::REM_W:0]    shifted;
		logic [dfrc_pkg::REM_W:0]    diff;
		logic                        ge;
		word_next = word_in;
		for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
			divisor = l[0] ? div_y : div_x;
			shifted = {word_in.lane[l].rem, word_in.lane[l].dq[dfrc_pkg::MAG_W-1]};
			diff    = shifted - {1'b0, divisor};
			ge      = (shifted >= {1'b0, divisor});
			word_next.lane[l].rem = ge ? diff[dfrc_pkg::REM_W-1:0]
			                           : shifted[dfrc_pkg::REM_W-1:0];
			word_next.lane[l].dq  = {word_in.lane[l].dq[dfrc_pkg::MAG_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_next;
		end
	end

	assign vld_out  = vld_q;
	assign word_out = word_q;

endmodule

>>> rtl/core/dfrc_front.sv
// ----------------------------------------------------------------------------
// dfrc_front: detection filter and scale multiply
// Decides whether a detection is kept, takes corner magnitudes and signs, and
// multiplies each magnitude by the image size ahead of the divider chain.
// ----------------------------------------------------------------------------
module dfrc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              accept,
	input  logic [dfrc_pkg::SCORE_W-1:0]      score,
	input  logic signed [dfrc_pkg::LABEL_W-1:0] class_label,
	input  logic signed [dfrc_pkg::COORD_W-1:0] left_edge,
	input  logic signed [dfrc_pkg::COORD_W-1:0] top_edge,
	input  logic signed [dfrc_pkg::COORD_W-1:0] right_edge,
	input  logic signed [dfrc_pkg::COORD_W-1:0] bottom_edge,
	input  logic                              frame_end_in,
	input  logic [dfrc_pkg::SCORE_W-1:0]      min_score,
	input  logic [dfrc_pkg::MASK_W-1:0]       class_mask,
	input  logic [dfrc_pkg::IMG_W-1:0]        image_width,
	input  logic [dfrc_pkg::IMG_W-1:0]        image_height,
	output logic                              vld_out,
	output dfrc_pkg::div_word_t               word_out
);

	logic [dfrc_pkg::COORD_W-1:0] coord [dfrc_pkg::NUM_LANES];
	logic [dfrc_pkg::COORD_W-1:0] mag   [dfrc_pkg::NUM_LANES];
	logic                         keep;
	logic                         in_range;
	dfrc_pkg::side_t              side;

	logic                         vld_s1;
	dfrc_pkg::side_t              side_s1;
	logic [dfrc_pkg::COORD_W-1:0] mag_s1 [dfrc_pkg::NUM_LANES];
	logic [dfrc_pkg::NUM_LANES-1:0] neg_s1;

	logic                         vld_s2;
	dfrc_pkg::div_word_t          word_s2;
	dfrc_pkg::div_word_t          word_next;

	assign coord[0] = left_edge;
	assign coord[1] = top_edge;
	assign coord[2] = right_edge;
	assign coord[3] = bottom_edge;

	assign in_range = !class_label[dfrc_pkg::LABEL_W-1] &&
	                  (class_label[dfrc_pkg::LABEL_W-2:0] <
	                   (dfrc_pkg::LABEL_W-1)'(dfrc_pkg::NUM_CLASSES));
	assign keep = (score >= min_score) && in_range &&
	              class_mask[class_label[dfrc_pkg::CLASS_W-1:0]];

	always_comb begin
		for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
			mag[l] = coord[l][dfrc_pkg::COORD_W-1] ? (~coord[l] + 1'b1) : coord[l];
		end
		side.class_id   = class_label[dfrc_pkg::CLASS_W-1:0];
		side.confidence = score;
		side.box_valid  = keep;
		side.frame_end  = frame_end_in;
	end

	always_comb begin
		logic [dfrc_pkg::COORD_W+dfrc_pkg::IMG_W-1:0] prod;
		word_next.side = side_s1;
		for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
			prod = {{dfrc_pkg::IMG_W{1'b0}}, mag_s1[l]} *
			       {{dfrc_pkg::COORD_W{1'b0}}, (l[0] ? image_height : image_width)};
			word_next.lane[l].rem = '0;
			word_next.lane[l].dq  = prod[dfrc_pkg::MAG_W-1:0];
			word_next.lane[l].neg = neg_s1[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept && (keep || frame_end_in);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
				mag_s1[l] <= mag[l];
				neg_s1[l] <= coord[l][dfrc_pkg::COORD_W-1];
			end
			word_s2 <= word_next;
		end
	end

	assign vld_out  = vld_s2;
	assign word_out = word_s2;

endmodule

>>> rtl/core/dfrc_back.sv
// ----------------------------------------------------------------------------
// dfrc_back: clip, pixel conversion and rectangle output
// Restores corner signs, clips to the image, converts to saturated integer
// pixels and forms the rectangle in the output register.
// ----------------------------------------------------------------------------
module dfrc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_in,
	input  dfrc_pkg::div_word_t               word_in,
	input  logic [dfrc_pkg::IMG_W-1:0]        image_width,
	input  logic [dfrc_pkg::IMG_W-1:0]        image_height,
	input  logic                              out_stall,
	output logic                              advance,
	output logic                              out_valid,
	output logic signed [dfrc_pkg::PIX_W-1:0] box_x,
	output logic signed [dfrc_pkg::PIX_W-1:0] box_y,
	output logic [dfrc_pkg::PIX_W-1:0]        box_width,
	output logic [dfrc_pkg::PIX_W-1:0]        box_height,
	output logic [dfrc_pkg::CLASS_W-1:0]      class_id,
	output logic [dfrc_pkg::SCORE_W-1:0]      confidence,
	output logic                              box_valid,
	output logic                              frame_end_out
);

	logic signed [dfrc_pkg::SV_W-1:0]  bound_x;
	logic signed [dfrc_pkg::SV_W-1:0]  bound_y;
	logic signed [dfrc_pkg::SV_W-1:0]  clip_next [dfrc_pkg::NUM_LANES];
	logic signed [dfrc_pkg::PIX_W-1:0] pix_next  [dfrc_pkg::NUM_LANES];

	logic                              vld_t1;
	dfrc_pkg::side_t                   side_t1;
	logic signed [dfrc_pkg::SV_W-1:0]  clip_t1 [dfrc_pkg::NUM_LANES];

	logic                              vld_t2;
	dfrc_pkg::side_t                   side_t2;
	logic signed [dfrc_pkg::PIX_W-1:0] pix_t2 [dfrc_pkg::NUM_LANES];

	logic                              out_valid_q;
	logic                              out_free;
	logic signed [dfrc_pkg::PIX_W-1:0] start_x;
	logic signed [dfrc_pkg::PIX_W-1:0] start_y;
	logic [dfrc_pkg::PIX_W-1:0]        len_x;
	logic [dfrc_pkg::PIX_W-1:0]        len_y;
	logic signed [dfrc_pkg::PIX_W-1:0] box_x_q;
	logic signed [dfrc_pkg::PIX_W-1:0] box_y_q;
	logic [dfrc_pkg::PIX_W-1:0]        box_width_q;
	logic [dfrc_pkg::PIX_W-1:0]        box_height_q;
	dfrc_pkg::side_t                   side_q;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = out_free || !vld_t2;

	assign bound_x = ({{(dfrc_pkg::SV_W-dfrc_pkg::IMG_W){1'b0}}, image_width} -
	                  dfrc_pkg::SV_W'(1)) <<< 4;
	assign bound_y = ({{(dfrc_pkg::SV_W-dfrc_pkg::IMG_W){1'b0}}, image_height} -
	                  dfrc_pkg::SV_W'(1)) <<< 4;

	always_comb begin
		logic signed [dfrc_pkg::SV_W-1:0] mag_ext;
		logic signed [dfrc_pkg::SV_W-1:0] sv;
		logic signed [dfrc_pkg::SV_W-1:0] bound;
		for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
			mag_ext = {1'b0, word_in.lane[l].dq};
			sv      = word_in.lane[l].neg ? -mag_ext : mag_ext;
			bound   = l[0] ? bound_y : bound_x;
			if (l < 2) begin
				clip_next[l] = (sv < 0) ? '0 : sv;
			end else begin
				clip_next[l] = (sv > bound) ? bound : sv;
			end
		end
	end

	always_comb begin
		logic signed [dfrc_pkg::SV_W-1:0] adj;
		logic signed [dfrc_pkg::TR_W-1:0] tr;
		for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
			adj = clip_t1[l][dfrc_pkg::SV_W-1] ?
			      (clip_t1[l] + dfrc_pkg::SV_W'(15)) : clip_t1[l];
			tr  = adj[dfrc_pkg::SV_W-1:4];
			if (tr > dfrc_pkg::PIX_MAX) begin
				pix_next[l] = dfrc_pkg::PIX_W'(dfrc_pkg::PIX_MAX);
			end else if (tr < dfrc_pkg::PIX_MIN) begin
				pix_next[l] = dfrc_pkg::PIX_W'(dfrc_pkg::PIX_MIN);
			end else begin
				pix_next[l] = tr[dfrc_pkg::PIX_W-1:0];
			end
		end
	end

	always_comb begin
		logic signed [dfrc_pkg::PIX_W:0] dx;
		logic signed [dfrc_pkg::PIX_W:0] dy;
		dx = {pix_t2[2][dfrc_pkg::PIX_W-1], pix_t2[2]} - {pix_t2[0][dfrc_pkg::PIX_W-1], pix_t2[0]};
		dy = {pix_t2[3][dfrc_pkg::PIX_W-1], pix_t2[3]} - {pix_t2[1][dfrc_pkg::PIX_W-1], pix_t2[1]};
		start_x = (pix_t2[0] < pix_t2[2]) ? pix_t2[0] : pix_t2[2];
		start_y = (pix_t2[1] < pix_t2[3]) ? pix_t2[1] : pix_t2[3];
		len_x   = dx[dfrc_pkg::PIX_W] ? dfrc_pkg::PIX_W'(-dx) : dx[dfrc_pkg::PIX_W-1:0];
		len_y   = dy[dfrc_pkg::PIX_W] ? dfrc_pkg::PIX_W'(-dy) : dy[dfrc_pkg::PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t1      <= 1'b0;
			vld_t2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				vld_t1 <= vld_in;
				vld_t2 <= vld_t1;
			end
			if (out_free) begin
				out_valid_q <= vld_t2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_t1 <= word_in.side;
			side_t2 <= side_t1;
			for (int l = 0; l < dfrc_pkg::NUM_LANES; l++) begin
				clip_t1[l] <= clip_next[l];
				pix_t2[l]  <= pix_next[l];
			end
		end
		if (out_free) begin
			side_q <= side_t2;
			if (side_t2.box_valid) begin
				box_x_q      <= start_x;
				box_y_q      <= start_y;
				box_width_q  <= len_x;
				box_height_q <= len_y;
			end else begin
				box_x_q      <= '0;
				box_y_q      <= '0;
				box_width_q  <= '0;
				box_height_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign box_x         = box_x_q;
	assign box_y         = box_y_q;
	assign box_width     = box_width_q;
	assign box_height    = box_height_q;
	assign class_id      = side_q.box_valid ? side_q.class_id : '0;
	assign confidence    = side_q.box_valid ? side_q.confidence : '0;
	assign box_valid     = side_q.box_valid;
	assign frame_end_out = side_q.frame_end;

endmodule

>>> rtl/core/detection_filter_rescale_clip.sv
// ----------------------------------------------------------------------------
// detection_filter_rescale_clip: detection filter with box rescale and clip
// Keeps detections by score, class range and class mask, rescales the kept
// box corners to the image size, clips them and emits integer rectangles.
// ----------------------------------------------------------------------------
// The block takes one detection per clock cycle while in_stall is low and
// passes each accepted item through the class filter and scale multiply
// stages, a chain of restoring divider cells that each produce one quotient
// bit of corner times image size over process size, and the clipping, pixel
// conversion and rectangle output stages. A rejected detection gives no
// result unless it closes a frame, in which case an empty end-of-frame item
// is returned. A result waiting on out_stall holds the pipeline only when
// the stage behind it is full.
module detection_filter_rescale_clip (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dfrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dfrc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dfrc_pkg::SCORE_W-1:0]         score,
	input  logic signed [dfrc_pkg::LABEL_W-1:0]  class_label,
	input  logic signed [dfrc_pkg::COORD_W-1:0]  left_edge,
	input  logic signed [dfrc_pkg::COORD_W-1:0]  top_edge,
	input  logic signed [dfrc_pkg::COORD_W-1:0]  right_edge,
	input  logic signed [dfrc_pkg::COORD_W-1:0]  bottom_edge,
	input  logic                                 frame_end_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dfrc_pkg::PIX_W-1:0]    box_x,
	output logic signed [dfrc_pkg::PIX_W-1:0]    box_y,
	output logic [dfrc_pkg::PIX_W-1:0]           box_width,
	output logic [dfrc_pkg::PIX_W-1:0]           box_height,
	output logic [dfrc_pkg::CLASS_W-1:0]         class_id,
	output logic [dfrc_pkg::SCORE_W-1:0]         confidence,
	output logic                                 box_valid,
	output logic                                 frame_end_out
);

	logic [dfrc_pkg::SCORE_W-1:0]   min_score_q;
	logic [dfrc_pkg::MASK_LO_W-1:0] class_mask_low_q;
	logic [dfrc_pkg::MASK_HI_W-1:0] class_mask_high_q;
	logic [dfrc_pkg::PROC_W-1:0]    process_width_q;
	logic [dfrc_pkg::PROC_W-1:0]    process_height_q;
	logic [dfrc_pkg::IMG_W-1:0]     image_width_q;
	logic [dfrc_pkg::IMG_W-1:0]     image_height_q;

	logic [dfrc_pkg::PROC_W-1:0]    div_x;
	logic [dfrc_pkg::PROC_W-1:0]    div_y;
	logic                           advance;
	logic                           accept;

	logic                           chain_vld  [dfrc_pkg::MAG_W+1];
	dfrc_pkg::div_word_t            chain_word [dfrc_pkg::MAG_W+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q       <= '0;
			class_mask_low_q  <= '0;
			class_mask_high_q <= '0;
			process_width_q   <= dfrc_pkg::PROC_W'(dfrc_pkg::DEFAULT_PROCESS);
			process_height_q  <= dfrc_pkg::PROC_W'(dfrc_pkg::DEFAULT_PROCESS);
			image_width_q     <= dfrc_pkg::IMG_W'(dfrc_pkg::DEFAULT_PROCESS);
			image_height_q    <= dfrc_pkg::IMG_W'(dfrc_pkg::DEFAULT_PROCESS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dfrc_pkg::REG_MIN_SCORE: begin
					min_score_q <= cfg_data[dfrc_pkg::SCORE_W-1:0];
				end
				dfrc_pkg::REG_CLASS_MASK_LOW: begin
					class_mask_low_q <= cfg_data[dfrc_pkg::MASK_LO_W-1:0];
				end
				dfrc_pkg::REG_CLASS_MASK_HIGH: begin
					class_mask_high_q <= cfg_data[dfrc_pkg::MASK_HI_W-1:0];
				end
				dfrc_pkg::REG_PROCESS_WIDTH: begin
					process_width_q <= cfg_data[dfrc_pkg::PROC_W-1:0];
				end
				dfrc_pkg::REG_PROCESS_HEIGHT: begin
					process_height_q <= cfg_data[dfrc_pkg::PROC_W-1:0];
				end
				dfrc_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[dfrc_pkg::IMG_W-1:0];
				end
				dfrc_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[dfrc_pkg::IMG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign div_x = (process_width_q == '0) ?
	               dfrc_pkg::PROC_W'(dfrc_pkg::DEFAULT_PROCESS) : process_width_q;
	assign div_y = (process_height_q == '0) ?
	               dfrc_pkg::PROC_W'(dfrc_pkg::DEFAULT_PROCESS) : process_height_q;

	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	dfrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.accept       (accept),
		.score        (score),
		.class_label  (class_label),
		.left_edge    (left_edge),
		.top_edge     (top_edge),
		.right_edge   (right_edge),
		.bottom_edge  (bottom_edge),
		.frame_end_in (frame_end_in),
		.min_score    (min_score_q),
		.class_mask   ({class_mask_high_q, class_mask_low_q}),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.vld_out      (chain_vld[0]),
		.word_out     (chain_word[0])
	);

	for (genvar i = 0; i < dfrc_pkg::MAG_W; i++) begin : g_cell
		dfrc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.vld_in   (chain_vld[i]),
			.word_in  (chain_word[i]),
			.div_x    (div_x),
			.div_y    (div_y),
			.vld_out  (chain_vld[i+1]),
			.word_out (chain_word[i+1])
		);
	end

	dfrc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.vld_in        (chain_vld[dfrc_pkg::MAG_W]),
		.word_in       (chain_word[dfrc_pkg::MAG_W]),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.out_stall     (out_stall),
		.advance       (advance),
		.out_valid     (out_valid),
		.box_x         (box_x),
		.box_y         (box_y),
		.box_width     (box_width),
		.box_height    (box_height),
		.class_id      (class_id),
		.confidence    (confidence),
		.box_valid     (box_valid),
		.frame_end_out (frame_end_out)
	);

endmodule
